// ----- hw/rtl/gbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared widths, limits and register indexes of the grid block partitioner.
// ----------------------------------------------------------------------------
package gbp_pkg;

  localparam int CELL_W  = 13;
  localparam int RANK_W  = 11;
  localparam int ID_W    = 10;
  localparam int OFF_W   = 12;
  localparam int MASK_W  = 4;
  localparam int PROD_W  = CELL_W + RANK_W;
  localparam int COST_W  = PROD_W + 1;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int DIV_STEPS = CELL_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  localparam logic [CELL_W-1:0] MAX_CELLS = CELL_W'(4096);
  localparam logic [RANK_W-1:0] MAX_RANKS = RANK_W'(1024);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_CELLS_X    = 2'd0;
  localparam reg_idx_t REG_CELLS_Y    = 2'd1;
  localparam reg_idx_t REG_RANK_COUNT = 2'd2;

  typedef struct packed {
    logic [RANK_W-1:0] procs_x;
    logic [RANK_W-1:0] procs_y;
    logic [CELL_W-1:0] local_x;
    logic [CELL_W-1:0] local_y;
    logic [OFF_W-1:0]  offset_x;
    logic [OFF_W-1:0]  offset_y;
    logic [MASK_W-1:0] boundary_mask;
    logic [ID_W-1:0]   left_rank;
    logic [ID_W-1:0]   right_rank;
    logic [ID_W-1:0]   bottom_rank;
    logic [ID_W-1:0]   top_rank;
    logic              lower_left_red;
  } res_t;

endpackage

// ----- hw/rtl/gbp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_in_if
// Query channel: one item names the rank whose partition is asked for.
// ----------------------------------------------------------------------------
interface gbp_in_if import gbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] rank_id;

  modport source (output valid, output rank_id, input ready);
  modport sink   (input valid, input rank_id, output ready);
endinterface

// ----- hw/rtl/gbp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_out_if
// Result channel: one item carries the partition of one rank.
// ----------------------------------------------------------------------------
interface gbp_out_if import gbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] procs_x;
  logic [RANK_W-1:0] procs_y;
  logic [CELL_W-1:0] local_x;
  logic [CELL_W-1:0] local_y;
  logic [OFF_W-1:0]  offset_x;
  logic [OFF_W-1:0]  offset_y;
  logic [MASK_W-1:0] boundary_mask;
  logic [ID_W-1:0]   left_rank;
  logic [ID_W-1:0]   right_rank;
  logic [ID_W-1:0]   bottom_rank;
  logic [ID_W-1:0]   top_rank;
  logic              lower_left_red;

  modport source (output valid, output procs_x, output procs_y, output local_x,
                  output local_y, output offset_x, output offset_y,
                  output boundary_mask, output left_rank, output right_rank,
                  output bottom_rank, output top_rank, output lower_left_red,
                  input ready);
  modport sink   (input valid, input procs_x, input procs_y, input local_x,
                  input local_y, input offset_x, input offset_y,
                  input boundary_mask, input left_rank, input right_rank,
                  input bottom_rank, input top_rank, input lower_left_red,
                  output ready);
endinterface

// ----- hw/rtl/grid_block_partitioner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_block_partitioner_unit
// 2D block decomposition of a global grid among a number of ranks.
// ----------------------------------------------------------------------------
// Usage: write cells_x, cells_y and rank_count over the APB port (byte
// addresses 0, 4 and 8) while the block is idle, then send a rank_id item on
// in_item. The block returns one result item on out_item: the process grid,
// the block size and offset of that rank, its boundary mask, its neighbor
// ranks and the parity of its lower-left cell.
// A query is handled by a sequencer around one restoring divider (one quotient
// bit per cycle) and one registered multiplier. The divisor search tries
// d = 1, 2, ... while d <= n / d, one division a trial, and scores each
// divisor found as both d x n/d and n/d x d; three more divisions and the
// offset products follow. One item is in work at a time; in_item.ready is
// high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it, and a
// following item finishes its work and then waits for that register.
// Reset sets all three registers to 1 and empties the block.
// ----------------------------------------------------------------------------
module grid_block_partitioner_unit import gbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  gbp_in_if.sink            in_item,
  gbp_out_if.source         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TDIV = 4'd1;
  localparam logic [3:0] S_TCHK = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_MY   = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_RDIV = 4'd6;
  localparam logic [3:0] S_XDIV = 4'd7;
  localparam logic [3:0] S_YDIV = 4'd8;
  localparam logic [3:0] S_MOX  = 4'd9;
  localparam logic [3:0] S_MOY  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [CELL_W-1:0] cells_x_r, cells_y_r;
  logic [RANK_W-1:0] rank_count_r;

  logic [3:0]        state_r, state_nxt;
  logic [CELL_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RANK_W-1:0] n_r, n_nxt;
  logic [ID_W-1:0]   rank_r, rank_nxt;
  logic [RANK_W-1:0] d_r, d_nxt;
  logic [COST_W-1:0] best_r, best_nxt;
  logic [RANK_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [RANK_W-1:0] cand_a_r, cand_a_nxt, cand_b_r, cand_b_nxt;
  logic              cand_swap_r, cand_swap_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [RANK_W-1:0] col_r, col_nxt;
  logic [ID_W-1:0]   row_r, row_nxt;
  logic [CELL_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [RANK_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [CELL_W-1:0] ox_r, ox_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic [CELL_W-1:0] div_num_r, div_num_nxt;
  logic [RANK_W-1:0] div_den_r, div_den_nxt;
  logic [CELL_W-1:0] div_quo_r, div_quo_nxt;
  logic [RANK_W-1:0] div_rem_r, div_rem_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [RANK_W:0]   div_trial;
  logic              div_ge;
  logic [CELL_W-1:0] quo_step;
  logic [RANK_W-1:0] rem_step;
  logic              div_last;

  logic [CELL_W-1:0] mul_a;
  logic [RANK_W-1:0] mul_b;
  logic [COST_W-1:0] cost;
  logic [CELL_W-1:0] in_cx, in_cy;
  logic [RANK_W-1:0] in_n;
  logic [ID_W-1:0]   in_rank;
  logic [CELL_W-1:0] oy, min_x, min_y;
  logic [RANK_W-1:0] rank_ext;
  logic              cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_CELLS_X:    prdata = DATA_W'(cells_x_r);
      REG_CELLS_Y:    prdata = DATA_W'(cells_y_r);
      REG_RANK_COUNT: prdata = DATA_W'(rank_count_r);
      default:        prdata = '0;
    endcase
  end

  // Restoring divider step.
  assign div_trial = {div_rem_r, div_num_r[CELL_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den_r};
  assign rem_step  = div_ge ? RANK_W'(div_trial - {1'b0, div_den_r})
                            : RANK_W'(div_trial);
  assign quo_step  = {div_quo_r[CELL_W-2:0], div_ge};
  assign div_last  = div_cnt_r == DCNT_W'(DIV_STEPS - 1);

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      S_MX: begin
        mul_a = cx_r;
        mul_b = cand_a_r - RANK_W'(1);
      end
      S_MY: begin
        mul_a = cy_r;
        mul_b = cand_b_r - RANK_W'(1);
      end
      S_MOX: begin
        mul_a = bx_r;
        mul_b = col_r;
      end
      S_MOY, S_OUT: begin
        mul_a = by_r;
        mul_b = RANK_W'(row_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign cost = COST_W'(acc_r) + COST_W'(prod_r);

  assign in_cx = (cells_x_r == '0) ? CELL_W'(1) :
                 (cells_x_r > MAX_CELLS) ? MAX_CELLS : cells_x_r;
  assign in_cy = (cells_y_r == '0) ? CELL_W'(1) :
                 (cells_y_r > MAX_CELLS) ? MAX_CELLS : cells_y_r;
  assign in_n  = (rank_count_r == '0) ? RANK_W'(1) :
                 (rank_count_r > MAX_RANKS) ? MAX_RANKS : rank_count_r;
  assign in_rank = (RANK_W'(in_item.rank_id) >= in_n) ? ID_W'(in_n - RANK_W'(1))
                                                      : in_item.rank_id;

  assign rank_ext = RANK_W'(rank_r);
  assign min_x = CELL_W'((col_r < rx_r) ? col_r : rx_r);
  assign min_y = CELL_W'((RANK_W'(row_r) < ry_r) ? RANK_W'(row_r) : ry_r);
  assign oy    = prod_r[CELL_W-1:0] + min_y;

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    n_nxt         = n_r;
    rank_nxt      = rank_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    cand_a_nxt    = cand_a_r;
    cand_b_nxt    = cand_b_r;
    cand_swap_nxt = cand_swap_r;
    acc_nxt       = acc_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    ox_nxt        = ox_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    div_num_nxt   = {div_num_r[CELL_W-2:0], 1'b0};
    div_den_nxt   = div_den_r;
    div_quo_nxt   = quo_step;
    div_rem_nxt   = rem_step;
    div_cnt_nxt   = div_cnt_r + DCNT_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          cx_nxt      = in_cx;
          cy_nxt      = in_cy;
          n_nxt       = in_n;
          rank_nxt    = in_rank;
          d_nxt       = RANK_W'(1);
          best_nxt    = '1;
          div_num_nxt = CELL_W'(in_n);
          div_den_nxt = RANK_W'(1);
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_last) begin
          state_nxt = S_TCHK;
        end
      end
      S_TCHK: begin
        if (div_quo_r < CELL_W'(d_r)) begin
          div_num_nxt = CELL_W'(rank_r);
          div_den_nxt = px_r;
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_RDIV;
        end else if (div_rem_r == '0) begin
          cand_a_nxt    = d_r;
          cand_b_nxt    = RANK_W'(div_quo_r);
          cand_swap_nxt = 1'b0;
          state_nxt     = S_MX;
        end else begin
          d_nxt       = d_r + RANK_W'(1);
          div_num_nxt = CELL_W'(n_r);
          div_den_nxt = d_r + RANK_W'(1);
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_TDIV;
        end
      end
      S_MX: begin
        state_nxt = S_MY;
      end
      S_MY: begin
        acc_nxt   = prod_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ((cost < best_r) || ((cost == best_r) && (cand_a_r < px_r))) begin
          best_nxt = cost;
          px_nxt   = cand_a_r;
          py_nxt   = cand_b_r;
        end
        if (!cand_swap_r) begin
          cand_a_nxt    = cand_b_r;
          cand_b_nxt    = cand_a_r;
          cand_swap_nxt = 1'b1;
          state_nxt     = S_MX;
        end else begin
          d_nxt       = d_r + RANK_W'(1);
          div_num_nxt = CELL_W'(n_r);
          div_den_nxt = d_r + RANK_W'(1);
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_TDIV;
        end
      end
      S_RDIV: begin
        if (div_last) begin
          col_nxt     = rem_step;
          row_nxt     = ID_W'(quo_step);
          div_num_nxt = cx_r;
          div_den_nxt = px_r;
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_XDIV;
        end
      end
      S_XDIV: begin
        if (div_last) begin
          bx_nxt      = quo_step;
          rx_nxt      = rem_step;
          div_num_nxt = cy_r;
          div_den_nxt = py_r;
          div_quo_nxt = '0;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_YDIV;
        end
      end
      S_YDIV: begin
        if (div_last) begin
          by_nxt    = quo_step;
          ry_nxt    = rem_step;
          state_nxt = S_MOX;
        end
      end
      S_MOX: begin
        state_nxt = S_MOY;
      end
      S_MOY: begin
        ox_nxt    = prod_r[CELL_W-1:0] + min_x;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          res_nxt.procs_x  = px_r;
          res_nxt.procs_y  = py_r;
          res_nxt.local_x  = bx_r + CELL_W'(col_r < rx_r);
          res_nxt.local_y  = by_r + CELL_W'(RANK_W'(row_r) < ry_r);
          res_nxt.offset_x = OFF_W'(ox_r);
          res_nxt.offset_y = OFF_W'(oy);
          res_nxt.boundary_mask  = '0;
          res_nxt.left_rank      = '0;
          res_nxt.right_rank     = '0;
          res_nxt.bottom_rank    = '0;
          res_nxt.top_rank       = '0;
          if (col_r == '0) begin
            res_nxt.boundary_mask[0] = 1'b1;
          end else begin
            res_nxt.left_rank = rank_r - ID_W'(1);
          end
          if (col_r == px_r - RANK_W'(1)) begin
            res_nxt.boundary_mask[1] = 1'b1;
          end else begin
            res_nxt.right_rank = rank_r + ID_W'(1);
          end
          if (rank_ext < px_r) begin
            res_nxt.boundary_mask[2] = 1'b1;
          end else begin
            res_nxt.bottom_rank = ID_W'(rank_ext - px_r);
          end
          if (rank_ext >= n_r - px_r) begin
            res_nxt.boundary_mask[3] = 1'b1;
          end else begin
            res_nxt.top_rank = ID_W'(rank_ext + px_r);
          end
          res_nxt.lower_left_red = ~(ox_r[0] ^ oy[0]);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cells_x_r    <= CELL_W'(1);
      cells_y_r    <= CELL_W'(1);
      rank_count_r <= RANK_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CELLS_X:    cells_x_r    <= pwdata[CELL_W-1:0];
          REG_CELLS_Y:    cells_y_r    <= pwdata[CELL_W-1:0];
          REG_RANK_COUNT: rank_count_r <= pwdata[RANK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    n_r         <= n_nxt;
    rank_r      <= rank_nxt;
    d_r         <= d_nxt;
    best_r      <= best_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    cand_a_r    <= cand_a_nxt;
    cand_b_r    <= cand_b_nxt;
    cand_swap_r <= cand_swap_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    ox_r        <= ox_nxt;
    res_r       <= res_nxt;
    div_num_r   <= div_num_nxt;
    div_den_r   <= div_den_nxt;
    div_quo_r   <= div_quo_nxt;
    div_rem_r   <= div_rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
  end

  assign in_item.ready           = state_r == S_IDLE;
  assign out_item.valid          = out_valid_r;
  assign out_item.procs_x        = res_r.procs_x;
  assign out_item.procs_y        = res_r.procs_y;
  assign out_item.local_x        = res_r.local_x;
  assign out_item.local_y        = res_r.local_y;
  assign out_item.offset_x       = res_r.offset_x;
  assign out_item.offset_y       = res_r.offset_y;
  assign out_item.boundary_mask  = res_r.boundary_mask;
  assign out_item.left_rank      = res_r.left_rank;
  assign out_item.right_rank     = res_r.right_rank;
  assign out_item.bottom_rank    = res_r.bottom_rank;
  assign out_item.top_rank       = res_r.top_rank;
  assign out_item.lower_left_red = res_r.lower_left_red;

  // The chosen process grid must tile the rank count exactly.
  a_grid_product: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOX) |-> ((22'(px_r) * 22'(py_r)) == 22'(n_r)))
    else $error("process grid does not match rank count");

  // The column of the rank lies inside the process grid.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOX) |-> (col_r < px_r))
    else $error("rank column outside process grid");

  // Division remainders stay below their divisors.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOX) |-> ((rx_r < px_r) && (ry_r < py_r)))
    else $error("cell remainder not below process count");

  // An accepted item makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("block ready right after accepting an item");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression of grid_block_partitioner_unit.
// Grid size and rank count are written over the APB port while the block is
// idle. Rank queries are then sent with random gaps, and every returned
// partition is compared field by field against a behavioral prediction of the
// process grid search, block sizes, offsets, boundary mask, neighbors and
// lower-left parity. Directed corner settings come first, then random settings
// with random ranks, a stretch without idling, and a long receiver stall that
// backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb_top;
  import gbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned END_WAIT    = 800;
  localparam int unsigned ITEMS_PER_PHASE = 30;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned MAX_REPORTS = 10;

  localparam reg_idx_t REG_SPARE = 2'd3;

  localparam int BND_LEFT   = 0;
  localparam int BND_RIGHT  = 1;
  localparam int BND_BOTTOM = 2;
  localparam int BND_TOP    = 3;

  localparam int unsigned RICH_COUNTS [0:7] = '{12, 36, 60, 120, 360, 720, 840, 960};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  gbp_in_if  in_item ();
  gbp_out_if out_item ();

  grid_block_partitioner_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [CELL_W-1:0] grid_cells_x = CELL_W'(1);
  logic [CELL_W-1:0] grid_cells_y = CELL_W'(1);
  logic [RANK_W-1:0] grid_ranks   = RANK_W'(1);

  res_t        pending_parts [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          idle_en     = 1'b1;
  bit          hold_armed  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_block_partitioner_unit regression: fail");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic int unsigned effective_ranks();
    if (grid_ranks == 0) return 1;
    if (grid_ranks > MAX_RANKS) return MAX_RANKS;
    return grid_ranks;
  endfunction

  function automatic int unsigned effective_cells(input logic [CELL_W-1:0] cells);
    if (cells == 0) return 1;
    if (cells > MAX_CELLS) return MAX_CELLS;
    return cells;
  endfunction

  function automatic res_t partition_of(input logic [ID_W-1:0] rid);
    int unsigned cx, cy, n, rank, px, py, best, cost, d;
    int unsigned col, row, bx, by, rx, ry, ox, oy;
    res_t p;
    cx = effective_cells(grid_cells_x);
    cy = effective_cells(grid_cells_y);
    n = effective_ranks();
    rank = (rid >= n) ? n - 1 : rid;
    px = 1;
    py = n;
    best = cy * (n - 1);
    for (d = 2; d <= n; d++) begin
      if (n % d == 0) begin
        cost = cx * (d - 1) + cy * (n / d - 1);
        if (cost < best) begin
          best = cost;
          px = d;
          py = n / d;
        end
      end
    end
    col = rank % px;
    row = rank / px;
    bx = cx / px;
    rx = cx % px;
    by = cy / py;
    ry = cy % py;
    ox = col * bx + ((col < rx) ? col : rx);
    oy = row * by + ((row < ry) ? row : ry);
    p = '0;
    p.procs_x  = RANK_W'(px);
    p.procs_y  = RANK_W'(py);
    p.local_x  = CELL_W'(bx + ((col < rx) ? 1 : 0));
    p.local_y  = CELL_W'(by + ((row < ry) ? 1 : 0));
    p.offset_x = OFF_W'(ox);
    p.offset_y = OFF_W'(oy);
    if (col == 0) p.boundary_mask[BND_LEFT] = 1'b1;
    else p.left_rank = ID_W'(rank - 1);
    if (col == px - 1) p.boundary_mask[BND_RIGHT] = 1'b1;
    else p.right_rank = ID_W'(rank + 1);
    if (rank < px) p.boundary_mask[BND_BOTTOM] = 1'b1;
    else p.bottom_rank = ID_W'(rank - px);
    if (rank >= px * (py - 1)) p.boundary_mask[BND_TOP] = 1'b1;
    else p.top_rank = ID_W'(rank + px);
    p.lower_left_red = ((ox + oy) % 2 == 0);
    return p;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  always @(negedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_item.valid && out_item.ready) begin
      got.procs_x        = out_item.procs_x;
      got.procs_y        = out_item.procs_y;
      got.local_x        = out_item.local_x;
      got.local_y        = out_item.local_y;
      got.offset_x       = out_item.offset_x;
      got.offset_y       = out_item.offset_y;
      got.boundary_mask  = out_item.boundary_mask;
      got.left_rank      = out_item.left_rank;
      got.right_rank     = out_item.right_rank;
      got.bottom_rank    = out_item.bottom_rank;
      got.top_rank       = out_item.top_rank;
      got.lower_left_red = out_item.lower_left_red;
      if (pending_parts.size() == 0) begin
        note_failure("result item with no query outstanding");
      end else begin
        want = pending_parts.pop_front();
        check_field("procs_x", want.procs_x, got.procs_x);
        check_field("procs_y", want.procs_y, got.procs_y);
        check_field("local_x", want.local_x, got.local_x);
        check_field("local_y", want.local_y, got.local_y);
        check_field("offset_x", want.offset_x, got.offset_x);
        check_field("offset_y", want.offset_y, got.offset_y);
        check_field("boundary_mask", want.boundary_mask, got.boundary_mask);
        check_field("left_rank", want.left_rank, got.left_rank);
        check_field("right_rank", want.right_rank, got.right_rank);
        check_field("bottom_rank", want.bottom_rank, got.bottom_rank);
        check_field("top_rank", want.top_rank, got.top_rank);
        check_field("lower_left_red", want.lower_left_red, got.lower_left_red);
      end
    end
  end

  initial begin : result_sink
    int unsigned held;
    out_item.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        out_item.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_armed = 1'b0;
      end
      out_item.ready <= rst_n && (!idle_en || $urandom_range(0, 99) >= 33);
    end
  end

  task automatic send_query(input logic [ID_W-1:0] rid);
    while (idle_en && $urandom_range(0, 99) < 33) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid   <= 1'b1;
    in_item.rank_id <= rid;
    do @(negedge clk); while (!in_item.ready);
    pending_parts.push_back(partition_of(rid));
    @(posedge clk);
  endtask

  task automatic drain_block();
    in_item.valid <= 1'b0;
    while (pending_parts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CELLS_X:    grid_cells_x = data[CELL_W-1:0];
      REG_CELLS_Y:    grid_cells_y = data[CELL_W-1:0];
      REG_RANK_COUNT: grid_ranks   = data[RANK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned cx, input int unsigned cy,
                          input int unsigned n);
    drain_block();
    write_reg(REG_CELLS_X, cx);
    write_reg(REG_CELLS_Y, cy);
    write_reg(REG_RANK_COUNT, n);
  endtask

  function automatic int unsigned pick_cells();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 8191);
      1, 2:    return $urandom_range(1, 64);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic int unsigned pick_ranks();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2047);
      1, 2:    return RICH_COUNTS[$urandom_range(0, 7)];
      3:       return MAX_RANKS;
      4, 5:    return $urandom_range(1, 64);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_rank();
    int unsigned n;
    n = effective_ranks();
    case ($urandom_range(0, 9))
      0:       return ID_W'($urandom);
      1:       return (n < 1024) ? ID_W'($urandom_range(n, 1023)) : ID_W'(1023);
      2:       return ID_W'(n - 1);
      default: return ID_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_query(ID_W'(0));
    send_query(ID_W'(1023));
  endtask

  task automatic test_extreme_grids();
    set_grid(4096, 4096, 1024);
    send_query(ID_W'(0));
    send_query(ID_W'(31));
    send_query(ID_W'(32));
    send_query(ID_W'(500));
    send_query(ID_W'(1023));
    set_grid(1, 1, 1024);
    send_query(ID_W'(0));
    send_query(ID_W'(517));
    send_query(ID_W'(1023));
  endtask

  task automatic test_cost_ties();
    set_grid(6, 6, 6);
    send_query(ID_W'(0));
    send_query(ID_W'(3));
    send_query(ID_W'(5));
    send_query(ID_W'(7));
  endtask

  task automatic test_zero_and_oversize();
    set_grid(0, 0, 0);
    send_query(ID_W'(5));
    set_grid(8191, 32'hFFFF_F001, 2047);
    send_query(ID_W'(0));
    send_query(ID_W'(1023));
  endtask

  task automatic test_prime_and_spare_register();
    set_grid(100, 3000, 1021);
    send_query(ID_W'(1020));
    send_query(ID_W'(1023));
    drain_block();
    write_reg(REG_SPARE, 5);
    send_query(ID_W'(7));
  endtask

  task automatic test_random_configs();
    int unsigned phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_grid(pick_cells(), pick_cells(), pick_ranks());
      repeat (ITEMS_PER_PHASE) send_query(pick_rank());
    end
  endtask

  task automatic test_no_idle();
    set_grid(1000, 700, 360);
    idle_en = 1'b0;
    repeat (40) send_query(pick_rank());
    drain_block();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    set_grid(64, 48, 12);
    hold_armed = 1'b1;
    repeat (6) send_query(pick_rank());
  endtask

  initial begin
    in_item.valid   = 1'b0;
    in_item.rank_id = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extreme_grids();
    test_cost_ties();
    test_zero_and_oversize();
    test_prime_and_spare_register();
    test_random_configs();
    test_no_idle();
    test_backpressure();

    drain_block();
    repeat (END_WAIT) @(posedge clk);
    if (pending_parts.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_parts.size()));
    end
    if (fail_count == 0) begin
      $display("grid_block_partitioner_unit regression: pass");
    end else begin
      $display("grid_block_partitioner_unit regression: fail");
    end
    $finish;
  end

endmodule
